// ===== rtl/core/lagrange_table_interpolator_macros.svh =====
// Assertion macros used by the checker file of the interpolator.
`ifndef LAGRANGE_TABLE_INTERPOLATOR_MACROS_SVH
`define LAGRANGE_TABLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LTI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("interpolator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LTI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("interpolator check failed");

`endif

// ===== rtl/core/lti_pkg.sv =====
// Shared types, codes and helpers of the Lagrange table interpolator.
`default_nettype none
package lti_pkg;

  // request kind on in_tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // item classes handed from front to back
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_BADIDX = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_UNSORTED  = 3'd2;
  localparam logic [2:0] ST_BAD_ORDER = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_POINTS = 2'd0;
  localparam logic [1:0] REG_ORDER  = 2'd1;

  localparam int PIU_W = 11;
  localparam int ORD_W = 4;
  localparam int IDX_W = 10;

  // divider widths: numerator (x - xj) << 16, denominator xi - xj
  localparam int NUM_W = 49;
  localparam int DEN_W = 33;
  localparam int DVD_W = 50;
  localparam int DVS_W = 34;

  typedef struct packed {
    logic [1:0]         kind;
    logic               empty;
    logic               order_bad;
    logic [IDX_W-1:0]   addr;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } item_t;

  typedef struct packed {
    logic [PIU_W-1:0] s;
    logic [ORD_W-1:0] n;
  } cfg_t;

  // saturate a sign and magnitude pair to signed 32 bits
  function automatic logic [31:0] sat_signmag(input logic neg, input logic [63:0] m);
    logic [31:0] r;
    if (!neg) begin
      r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end else begin
      r = (m > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/lti_fifo.sv =====
// Two-entry queue between the classifying front and the executing back.
`default_nettype none
module lti_fifo
  import lti_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   push,
  input  item_t push_data,
  output logic  full,
  input  wire   pop,
  output item_t pop_data,
  output logic  valid
);

  item_t       mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = mem_r[rp_r];

  // store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lti_div.sv =====
// Restoring divider, one quotient bit a cycle, rounds half away from zero.
`default_nettype none
module lti_div
  import lti_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire signed [NUM_W-1:0] num,
  input  wire signed [DEN_W-1:0] den,
  output logic                   done,
  output logic [31:0]            q
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r, rem_r;
  logic [31:0]      q_r;
  logic [NUM_W-1:0] ua;
  logic [DEN_W-1:0] ub;
  logic [DVS_W:0]   trial;
  logic             take;

  assign ua    = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
  assign ub    = den[DEN_W-1] ? (DEN_W'(0) - den) : den;
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign take  = (trial >= {1'b0, dvs_r});
  assign done  = done_r;
  assign q     = q_r;

  // load operands, shift one bit per cycle, saturate at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        dvd_r  <= (DVD_W'(ua) << 1) + DVD_W'(ub);
        dvs_r  <= DVS_W'(ub) << 1;
        rem_r  <= '0;
        neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          rem_r <= take ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
          dvd_r <= {dvd_r[DVD_W-2:0], take};
          cnt_r <= cnt_r - CNT_W'(1);
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          q_r    <= sat_signmag(neg_r, 64'(dvd_r));
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lti_front.sv =====
// Front: configuration registers, input transfer and item classification.
`default_nettype none
module lti_front
  import lti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_ORDER   = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [79:0] in_tdata,
  input  wire  [0:0]  in_tuser,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         q_full,
  output logic        q_push,
  output item_t       q_item,
  output cfg_t        cfg
);

  logic [PIU_W-1:0] piu_r;
  logic [ORD_W-1:0] ord_r;
  logic [PIU_W-1:0] s;
  logic [IDX_W-1:0] idx;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  // hold configuration written over the cfg channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= PIU_W'(1024);
      ord_r <= ORD_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_POINTS) piu_r <= cfg_data[PIU_W-1:0];
      else if (cfg_index == REG_ORDER) ord_r <= cfg_data[ORD_W-1:0];
    end
  end

  // clamp the table size to the memory depth
  assign s     = (32'(piu_r) > TABLE_DEPTH) ? PIU_W'(TABLE_DEPTH) : piu_r;
  assign cfg.s = s;
  assign cfg.n = ord_r;
  assign idx   = in_tdata[9:0];

  // classify the incoming item
  always_comb begin
    q_item.addr      = idx;
    q_item.x         = in_tdata[41:10];
    q_item.y         = in_tdata[73:42];
    q_item.empty     = (s == '0);
    q_item.order_bad = (ord_r == '0) || (32'(ord_r) > MAX_ORDER)
                       || (PIU_W'(ord_r) > s);
    if (in_tuser[0] == REQ_QUERY) q_item.kind = KIND_QUERY;
    else if (32'(idx) < TABLE_DEPTH) q_item.kind = KIND_LOAD;
    else q_item.kind = KIND_BADIDX;
  end

endmodule
`default_nettype wire

// ===== rtl/core/lti_back.sv =====
// Back: table memories, search, window check and Lagrange evaluation.
`default_nettype none
module lti_back
  import lti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  input  cfg_t         cfg,
  output logic         out_valid,
  input  wire          out_ready,
  output logic [31:0]  out_y,
  output logic [2:0]   out_status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [3:0] S_IDLE = 4'd0,  S_DISP = 4'd1,  S_R0  = 4'd2,  S_R1  = 4'd3,
                         S_BS   = 4'd4,  S_BSW  = 4'd5,  S_AC0 = 4'd6,  S_ACR = 4'd7,
                         S_TI   = 4'd8,  S_TL   = 4'd9,  S_TJ  = 4'd10, S_TD  = 4'd11,
                         S_TW   = 4'd12, S_TR   = 4'd13, S_TE  = 4'd14, S_FIN = 4'd15;

  logic signed [31:0] x_mem [TABLE_DEPTH];
  logic signed [31:0] y_mem [TABLE_DEPTH];
  logic signed [31:0] rd_x_r, rd_y_r;

  logic [3:0]         state_r;
  item_t              cur_r;
  logic               unsorted_r;
  logic signed [31:0] last_x_r;
  logic signed [31:0] x0_r, prev_r, xi_r, term_r;
  logic signed [63:0] prod_r;
  logic signed [39:0] sum_r;
  logic [PIU_W-1:0]   il_r, ir_r, st_r;
  logic [3:0]         k_r, ci_r, cj_r;
  logic [31:0]        res_y_r;
  logic [2:0]         res_st_r;
  logic               out_valid_r;
  logic [31:0]        out_y_r;
  logic [2:0]         out_st_r;

  logic [PIU_W-1:0]   rd_idx, mid, nh, nn, st_new;
  logic [PIU_W:0]     pair_sum;
  logic               we, div_start, div_done;
  logic [31:0]        div_q;
  logic signed [32:0] diff_x, diff_i;
  logic signed [NUM_W-1:0] div_num;
  logic [3:0]         n_last;
  logic [63:0]        pmag;
  logic [63:0]        prnd;
  logic [31:0]        term_new;
  logic signed [39:0] sum_new;

  assign out_valid  = out_valid_r;
  assign out_y      = out_y_r;
  assign out_status = out_st_r;
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign we         = (state_r == S_DISP) && (cur_r.kind == KIND_LOAD);
  assign n_last     = cfg.n - 4'd1;

  // write on load, read with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[AW'(cur_r.addr)] <= cur_r.x;
      y_mem[AW'(cur_r.addr)] <= cur_r.y;
    end
    rd_x_r <= x_mem[AW'(rd_idx)];
    rd_y_r <= y_mem[AW'(rd_idx)];
  end

  // search midpoint and window start
  assign pair_sum = {1'b0, il_r} + {1'b0, ir_r};
  assign mid      = pair_sum[PIU_W:1];
  assign nh       = PIU_W'(cfg.n[3:1]);
  assign nn       = PIU_W'(cfg.n);

  always_comb begin
    if (!cfg.n[0]) begin
      if (ir_r < nh) st_new = '0;
      else if (ir_r > cfg.s - nh) st_new = cfg.s - nn;
      else st_new = ir_r - nh;
    end else begin
      if (il_r < nh) st_new = '0;
      else if (ir_r >= cfg.s - nh) st_new = cfg.s - nn;
      else st_new = il_r - nh;
    end
  end

  // pick the table address read in each state
  always_comb begin
    rd_idx = '0;
    unique case (state_r)
      S_R0:    rd_idx = cfg.s - PIU_W'(1);
      S_BS:    rd_idx = mid;
      S_AC0:   rd_idx = st_r;
      S_ACR:   rd_idx = st_r + PIU_W'(k_r) + PIU_W'(1);
      S_TI:    rd_idx = st_r + PIU_W'(ci_r);
      S_TJ:    rd_idx = st_r + PIU_W'(cj_r);
      default: rd_idx = '0;
    endcase
  end

  // divider operands: (x - xj) << 16 over (xi - xj)
  assign diff_x    = 33'(cur_r.x) - 33'(rd_x_r);
  assign diff_i    = 33'(xi_r) - 33'(rd_x_r);
  assign div_num   = {diff_x, 16'h0000};
  assign div_start = (state_r == S_TD);

  lti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (diff_i),
    .done  (div_done),
    .q     (div_q)
  );

  // round the product by 2^16 and saturate
  assign pmag     = prod_r[63] ? (64'd0 - prod_r) : prod_r;
  assign prnd     = (pmag + 64'd32768) >> 16;
  assign term_new = sat_signmag(prod_r[63], prnd);
  assign sum_new  = sum_r + 40'(term_r);

  // sequence one item at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      unsorted_r  <= 1'b0;
      last_x_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cur_r   <= q_item;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          res_y_r  <= '0;
          res_st_r <= ST_OK;
          unique case (cur_r.kind)
            KIND_LOAD: begin
              if (cur_r.addr == '0) unsorted_r <= 1'b0;
              else if (cur_r.x <= last_x_r) unsorted_r <= 1'b1;
              last_x_r <= cur_r.x;
              state_r  <= S_FIN;
            end
            KIND_QUERY: begin
              if (cur_r.empty) begin
                res_st_r <= ST_BAD_ORDER;
                state_r  <= S_FIN;
              end else begin
                state_r <= S_R0;
              end
            end
            default: begin
              res_st_r <= ST_BAD_INDEX;
              state_r  <= S_FIN;
            end
          endcase
        end
        S_R0: begin
          x0_r    <= rd_x_r;
          state_r <= S_R1;
        end
        S_R1: begin
          priority if (cur_r.x < x0_r || cur_r.x > rd_x_r) begin
            res_st_r <= ST_RANGE;
            state_r  <= S_FIN;
          end else if (cur_r.order_bad) begin
            res_st_r <= ST_BAD_ORDER;
            state_r  <= S_FIN;
          end else if (unsorted_r) begin
            res_st_r <= ST_UNSORTED;
            state_r  <= S_FIN;
          end else begin
            il_r    <= '0;
            ir_r    <= cfg.s - PIU_W'(1);
            sum_r   <= '0;
            state_r <= S_BS;
          end
        end
        S_BS: begin
          if (({1'b0, il_r} + (PIU_W+1)'(1)) < {1'b0, ir_r}) begin
            state_r <= S_BSW;
          end else begin
            st_r    <= st_new;
            state_r <= S_AC0;
          end
        end
        S_BSW: begin
          if (cur_r.x >= rd_x_r) il_r <= mid;
          else ir_r <= mid;
          state_r <= S_BS;
        end
        S_AC0: begin
          k_r     <= '0;
          state_r <= S_ACR;
        end
        S_ACR: begin
          prev_r <= rd_x_r;
          if (k_r != '0 && rd_x_r <= prev_r) begin
            res_st_r <= ST_UNSORTED;
            state_r  <= S_FIN;
          end else if (k_r == n_last) begin
            ci_r    <= '0;
            state_r <= S_TI;
          end else begin
            k_r <= k_r + 4'd1;
          end
        end
        S_TI: begin
          state_r <= S_TL;
        end
        S_TL: begin
          xi_r    <= rd_x_r;
          term_r  <= rd_y_r;
          cj_r    <= '0;
          state_r <= S_TJ;
        end
        S_TJ: begin
          if (cj_r == ci_r) begin
            if (cj_r == n_last) state_r <= S_TE;
            else cj_r <= cj_r + 4'd1;
          end else begin
            state_r <= S_TD;
          end
        end
        S_TD: begin
          state_r <= S_TW;
        end
        S_TW: begin
          if (div_done) begin
            prod_r  <= term_r * $signed(div_q);
            state_r <= S_TR;
          end
        end
        S_TR: begin
          term_r <= term_new;
          if (cj_r == n_last) begin
            state_r <= S_TE;
          end else begin
            cj_r    <= cj_r + 4'd1;
            state_r <= S_TJ;
          end
        end
        S_TE: begin
          sum_r <= sum_new;
          if (ci_r == n_last) begin
            res_y_r <= (sum_new > 40'sh00_7FFF_FFFF) ? 32'h7FFF_FFFF :
                       (sum_new < -40'sh00_8000_0000) ? 32'h8000_0000 : sum_new[31:0];
            state_r <= S_FIN;
          end else begin
            ci_r    <= ci_r + 4'd1;
            state_r <= S_TI;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_y_r     <= res_y_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lagrange_table_interpolator.sv =====
// Top level of the Lagrange table interpolator.
//
//   channel | direction | transfer on            | payload
//   in_     | input     | in_tvalid & in_tready  | tdata: index, x, y; tuser: kind
//   out_    | output    | out_tvalid & out_tready| tdata: y_result, status
//   cfg_    | input     | cfg_valid & cfg_ready  | register index, write data
//
// A load passes through IDLE, DISP and FIN; a query rejected before the search
// ends in DISP or after R0 and R1. A full query adds the binary search, the window
// read and one divide per ordered pair of distinct window points on the single
// 50-step divider, one quotient bit per cycle. rst_n is synchronous; configuration
// resets to 1024 points and order 4. The two-entry queue keeps taking items while
// the back works or the output register waits; in_tready drops only when the queue is full.
`default_nettype none
module lagrange_table_interpolator
  import lti_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int MAX_ORDER   = 8
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [79:0] in_tdata,   // entry_index[9:0], x_value[41:10], y_value[73:42], zero
  input  wire  [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // y_result[31:0], status[34:32], zero
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  item_t       q_in, q_out;
  cfg_t        cfg;
  logic        q_full, q_push, q_pop, q_valid;
  logic [31:0] res_y;
  logic [2:0]  res_st;

  lti_front #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_ORDER   (MAX_ORDER)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in),
    .cfg       (cfg)
  );

  lti_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .valid     (q_valid)
  );

  lti_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_out),
    .q_pop      (q_pop),
    .cfg        (cfg),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_y      (res_y),
    .out_status (res_st)
  );

  // pack the result
  assign out_tdata = {5'b00000, res_st, res_y};

endmodule
`default_nettype wire

// ===== rtl/core/lti_checker.sv =====
// Port-level checks of the interpolator and their bind.
`default_nettype none
`include "lagrange_table_interpolator_macros.svh"
module lti_checker
  import lti_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata
);

  `LTI_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `LTI_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))
  `LTI_ASSERT_IMP(a_fail_zero, out_tvalid && out_tdata[34:32] != ST_OK, out_tdata[31:0] == 32'd0)
  `LTI_ASSERT_IMP(a_status_code, out_tvalid, out_tdata[34:32] <= ST_BAD_INDEX && out_tdata[39:35] == 5'd0)

endmodule

bind lagrange_table_interpolator lti_checker u_lti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
